// ===== src/bcdm_pkg.sv =====
// ----------------------------------------------------------------------------
// Block cache drive mapper package
// Shared constants, codes and interface structs for the mapper block.
// ----------------------------------------------------------------------------
package bcdm_pkg;

  // Sizing
  localparam int SLOTS     = 3;
  localparam int MAP_BYTES = 8192;
  localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Cached map organization: rows of MAP_W bits.
  localparam int MAP_W    = 32;
  localparam int BIT_AW   = $clog2(MAP_W);
  localparam int MAP_BITS = MAP_BYTES * 8;
  localparam int MAP_ROWS = MAP_BITS / MAP_W;
  localparam int ROW_AW   = $clog2(MAP_ROWS);

  // Constants of the function
  localparam logic [15:0] CATALOG_BLOCK  = 16'hFFFF;
  localparam logic [15:0] MOUNT_BASE_RST = 16'd1024;
  localparam logic [15:0] PROT_RST       = 16'd280;
  localparam int          BLOCK_SHIFT    = 9;   // 512-byte blocks

  // Command codes
  localparam logic [2:0] CMD_LOOKUP = 3'd0;
  localparam logic [2:0] CMD_WRITE  = 3'd1;
  localparam logic [2:0] CMD_MARK   = 3'd2;
  localparam logic [2:0] CMD_MOUNT  = 3'd3;
  localparam logic [2:0] CMD_CLOSE  = 3'd4;

  // Result action codes
  localparam logic [2:0] ACT_CATALOG   = 3'd0;
  localparam logic [2:0] ACT_HIT       = 3'd1;
  localparam logic [2:0] ACT_OWNED     = 3'd2;
  localparam logic [2:0] ACT_OUT       = 3'd3;
  localparam logic [2:0] ACT_MOUNT_OK  = 3'd4;
  localparam logic [2:0] ACT_MOUNT_ERR = 3'd5;
  localparam logic [2:0] ACT_DONE      = 3'd6;

  // Configuration register indexes
  localparam logic REG_MOUNT_BASE = 1'b0;
  localparam logic REG_PROTECTED  = 1'b1;

  // Shared adder request and response
  typedef struct packed {
    logic        sub;
    logic [31:0] a;
    logic [31:0] b;
    logic [15:0] c;
  } alu_req_t;

  typedef struct packed {
    logic [32:0] sum;
    logic        lt;
  } alu_rsp_t;

  // Cached map request and status
  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic [ROW_AW-1:0] addr;
    logic [MAP_W-1:0]  wr_data;
    logic              sweep_start;
    logic [15:0]       sweep_count;
  } map_req_t;

  typedef struct packed {
    logic             busy;
    logic [MAP_W-1:0] rd_data;
  } map_stat_t;

endpackage

// ===== src/bcdm_alu.sv =====
// ----------------------------------------------------------------------------
// Block cache drive mapper shared adder
// One 32-bit add/subtract with a range compare of the low half of the result.
// ----------------------------------------------------------------------------
module bcdm_alu (
  input  bcdm_pkg::alu_req_t req,
  output bcdm_pkg::alu_rsp_t rsp
);

  logic [32:0] sum;

  // For subtraction, sum[32] is the borrow: set when a < b.
  assign sum = req.sub ? ({1'b0, req.a} - {1'b0, req.b}) : ({1'b0, req.a} + {1'b0, req.b});

  assign rsp.sum = sum;
  assign rsp.lt  = !sum[32] && (sum[31:16] == 16'd0) && (sum[15:0] < req.c);

endmodule

// ===== src/bcdm_map.sv =====
// ----------------------------------------------------------------------------
// Block cache drive mapper cached map
// Row-organized bit map memory with a clearing and preset sweep.
// ----------------------------------------------------------------------------
module bcdm_map (
  input  logic                clk,
  input  logic                rst,
  input  bcdm_pkg::map_req_t  req,
  output bcdm_pkg::map_stat_t stat
);

  localparam int ROW_AW = bcdm_pkg::ROW_AW;
  localparam int MAP_W  = bcdm_pkg::MAP_W;
  localparam int BIT_AW = bcdm_pkg::BIT_AW;

  logic [MAP_W-1:0]  mem [bcdm_pkg::MAP_ROWS];
  logic [MAP_W-1:0]  rd_data;
  logic              busy;
  logic [ROW_AW-1:0] row;
  logic [15:0]       prot;

  logic [16:0]      row_base;
  logic [17:0]      remain;
  logic [MAP_W-1:0] preset;

  // Bits of the current row that fall below the protected count are set.
  always_comb begin
    row_base = 17'({row, {BIT_AW{1'b0}}});
    remain   = {2'b00, prot} - {1'b0, row_base};
    if (remain[17]) begin
      preset = '0;
    end else if (remain[16:0] >= 17'(MAP_W)) begin
      preset = '1;
    end else begin
      preset = ~({MAP_W{1'b1}} << remain[BIT_AW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      row  <= '0;
      prot <= '0;
    end else if (req.sweep_start) begin
      busy <= 1'b1;
      row  <= '0;
      prot <= req.sweep_count;
    end else if (busy) begin
      if (row == ROW_AW'(bcdm_pkg::MAP_ROWS - 1)) begin
        busy <= 1'b0;
      end else begin
        row <= row + ROW_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[row] <= preset;
    end else if (req.wr_en) begin
      mem[req.addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.addr];
    end
  end

  assign stat.busy    = busy;
  assign stat.rd_data = rd_data;

endmodule

// ===== src/block_cache_drive_mapper_unit.sv =====
// ----------------------------------------------------------------------------
// Block cache drive mapper
// Classifies block requests against a cached bit map and a drive slot table,
// and places mounted volumes one after another in the block space.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                 Contents
// s_*       in         s_tvalid / s_tready       command (tuser), request fields
// m_*       out        m_tvalid / m_tready       action (tuser), result fields
// apb       in         psel, penable, pready=1   mount_base, protected_blocks
//
// Transaction steps: close all, a rejected mount slot and an unknown command go
// from the accept straight to the emit step; a catalog block, a hit and a mark
// first read the map row; read misses and write lookups then scan, as the shared
// adder checks one slot per cycle from the highest down and then adds the file
// offset. A mount walks the lower slots in rising order for the free pointer,
// places the volume and then, if it fits, runs the map clearing pass.
// The clearing pass writes one map row per cycle over MAP_ROWS = 2048 rows; it
// runs after reset and after every successful mount, and s_tready stays low.
// Reset is synchronous; all slots close and the map is cleared by that pass.
// A result waits in the output register while m_tready is low; the next
// request is still accepted, and its own result waits until the register frees.
//
module block_cache_drive_mapper_unit (
  input  logic        clk,
  input  logic        rst,

  input  logic        s_tvalid,
  output logic        s_tready,
  // [15:0] block, [17:16] slot, [33:18] volume_blocks, [65:34] volume_offset
  input  logic [71:0] s_tdata,
  // [2:0] command
  input  logic [2:0]  s_tuser,

  output logic        m_tvalid,
  input  logic        m_tready,
  // [1:0] drive_index, [17:2] local_block, [49:18] file_offset, [65:50] base_block
  output logic [71:0] m_tdata,
  // [2:0] action
  output logic [2:0]  m_tuser,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SLOTS  = bcdm_pkg::SLOTS;
  localparam int SLOT_W = bcdm_pkg::SLOT_W;
  localparam int ROW_AW = bcdm_pkg::ROW_AW;
  localparam int BIT_AW = bcdm_pkg::BIT_AW;
  localparam int MAP_W  = bcdm_pkg::MAP_W;

  localparam logic [bcdm_pkg::BLOCK_SHIFT-1:0] BLOCK_ZEROS = '0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_OFFSET,
    S_NF,
    S_PLACE,
    S_EMIT
  } state_t;

  state_t state;

  // Configuration registers
  logic [15:0] mount_base;
  logic [15:0] protected_blocks;

  // Drive slot table
  logic [SLOTS-1:0] slot_open;
  logic [15:0]      slot_base   [SLOTS];
  logic [15:0]      slot_count  [SLOTS];
  logic [31:0]      slot_offset [SLOTS];

  // Working registers: free pointer, captured request, scan index
  logic [17:0]       nf;
  logic [2:0]        cmd;
  logic [15:0]       blk;
  logic [SLOT_W-1:0] mslot;
  logic [15:0]       vblocks;
  logic [31:0]       voffset;
  logic [SLOT_W-1:0] idx;

  // Result being built
  logic [2:0]  res_action;
  logic [1:0]  res_drive;
  logic [15:0] res_local;
  logic [31:0] res_file;
  logic [15:0] res_base;

  bcdm_pkg::alu_req_t  alu_req;
  bcdm_pkg::alu_rsp_t  alu_rsp;
  bcdm_pkg::map_req_t  map_req;
  bcdm_pkg::map_stat_t map_stat;

  logic in_accept;
  logic in_map;
  logic map_bit;
  logic nf_fits;
  logic in_slot_ok;

  bcdm_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  bcdm_map u_map (
    .clk  (clk),
    .rst  (rst),
    .req  (map_req),
    .stat (map_stat)
  );

  assign s_tready  = (state == S_IDLE) && !map_stat.busy;
  assign in_accept = s_tvalid && s_tready;

  // Blocks beyond the map read as not cached and cannot be marked.
  assign in_map     = ({1'b0, blk} < 17'(bcdm_pkg::MAP_BITS));
  assign map_bit    = map_stat.rd_data[blk[BIT_AW-1:0]];
  assign nf_fits    = (nf[17:16] == 2'b00);
  assign in_slot_ok = (32'(s_tdata[17:16]) < SLOTS);

  // APB: always ready, registers decoded by word address.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == bcdm_pkg::REG_PROTECTED) ? {16'd0, protected_blocks}
                                                         : {16'd0, mount_base};

  always_ff @(posedge clk) begin
    if (rst) begin
      mount_base       <= bcdm_pkg::MOUNT_BASE_RST;
      protected_blocks <= bcdm_pkg::PROT_RST;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == bcdm_pkg::REG_PROTECTED) begin
        protected_blocks <= pwdata[15:0];
      end else begin
        mount_base <= pwdata[15:0];
      end
    end
  end

  // The shared adder: operands follow the sequencer state.
  always_comb begin
    alu_req = '0;
    case (state)
      S_SCAN: begin
        alu_req.sub = 1'b1;
        alu_req.a   = {16'd0, blk};
        alu_req.b   = {16'd0, slot_base[idx]};
        alu_req.c   = slot_count[idx];
      end
      S_OFFSET: begin
        alu_req.a = slot_offset[idx];
        alu_req.b = 32'({res_local, BLOCK_ZEROS});
      end
      S_NF: begin
        alu_req.a = {16'd0, slot_base[idx]};
        alu_req.b = {16'd0, slot_count[idx]};
      end
      S_PLACE: begin
        alu_req.a = {14'd0, nf};
        alu_req.b = {16'd0, vblocks};
      end
      default: begin
        alu_req = '0;
      end
    endcase
  end

  // Map port: the row read is issued with the accept; a mark writes it back.
  always_comb begin
    map_req             = '0;
    map_req.sweep_count = protected_blocks;
    if (in_accept) begin
      map_req.rd_en = 1'b1;
      map_req.addr  = s_tdata[BIT_AW +: ROW_AW];
    end else begin
      map_req.addr = blk[BIT_AW +: ROW_AW];
    end
    map_req.wr_data = map_stat.rd_data | (MAP_W'(1) << blk[BIT_AW-1:0]);
    map_req.wr_en   = (state == S_READ) && (cmd == bcdm_pkg::CMD_MARK) && in_map;
    map_req.sweep_start = (state == S_PLACE) && nf_fits;
  end

  // Sequencer, slot table and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      slot_open <= '0;
      nf        <= 18'(bcdm_pkg::MOUNT_BASE_RST);
      m_tvalid  <= 1'b0;
    end else begin
      // The emit step reloads the register itself when it is taken.
      if (m_tvalid && m_tready && (state != S_EMIT)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            cmd        <= s_tuser;
            blk        <= s_tdata[15:0];
            mslot      <= SLOT_W'(s_tdata[17:16]);
            vblocks    <= s_tdata[33:18];
            voffset    <= s_tdata[65:34];
            res_drive  <= '0;
            res_local  <= '0;
            res_file   <= '0;
            res_base   <= '0;
            case (s_tuser)
              bcdm_pkg::CMD_LOOKUP, bcdm_pkg::CMD_WRITE, bcdm_pkg::CMD_MARK: begin
                idx        <= SLOT_W'(SLOTS - 1);
                res_action <= bcdm_pkg::ACT_DONE;
                state      <= S_READ;
              end
              bcdm_pkg::CMD_MOUNT: begin
                if (!in_slot_ok) begin
                  res_action <= bcdm_pkg::ACT_MOUNT_ERR;
                  state      <= S_EMIT;
                end else begin
                  // Close the given slot and every higher one.
                  for (int d = 0; d < SLOTS; d++) begin
                    if (d >= 32'(s_tdata[17:16])) begin
                      slot_open[d] <= 1'b0;
                    end
                  end
                  nf  <= {2'b00, mount_base};
                  idx <= '0;
                  if (s_tdata[17:16] == 2'd0) begin
                    state <= S_PLACE;
                  end else begin
                    state <= S_NF;
                  end
                end
              end
              bcdm_pkg::CMD_CLOSE: begin
                slot_open  <= '0;
                nf         <= {2'b00, mount_base};
                res_action <= bcdm_pkg::ACT_DONE;
                state      <= S_EMIT;
              end
              default: begin
                res_action <= bcdm_pkg::ACT_DONE;
                state      <= S_EMIT;
              end
            endcase
          end
        end

        S_READ: begin
          // Map row data is valid here.
          if (cmd == bcdm_pkg::CMD_MARK) begin
            state <= S_EMIT;
          end else if ((cmd == bcdm_pkg::CMD_LOOKUP) && (blk == bcdm_pkg::CATALOG_BLOCK)) begin
            res_action <= bcdm_pkg::ACT_CATALOG;
            state      <= S_EMIT;
          end else if ((cmd == bcdm_pkg::CMD_LOOKUP) && in_map && map_bit) begin
            res_action <= bcdm_pkg::ACT_HIT;
            state      <= S_EMIT;
          end else begin
            state <= S_SCAN;
          end
        end

        S_SCAN: begin
          // One slot per cycle, highest first; the first owner wins.
          if (slot_open[idx] && alu_rsp.lt) begin
            res_local <= alu_rsp.sum[15:0];
            res_drive <= 2'(idx);
            state     <= S_OFFSET;
          end else if (idx == '0) begin
            res_action <= bcdm_pkg::ACT_OUT;
            state      <= S_EMIT;
          end else begin
            idx <= idx - SLOT_W'(1);
          end
        end

        S_OFFSET: begin
          res_action <= bcdm_pkg::ACT_OWNED;
          res_file   <= alu_rsp.sum[31:0];
          state      <= S_EMIT;
        end

        S_NF: begin
          // Lower slots in rising order; the last open one sets the pointer.
          if (slot_open[idx]) begin
            nf <= alu_rsp.sum[17:0];
          end
          if (idx == mslot - SLOT_W'(1)) begin
            state <= S_PLACE;
          end else begin
            idx <= idx + SLOT_W'(1);
          end
        end

        S_PLACE: begin
          if (!nf_fits) begin
            res_action <= bcdm_pkg::ACT_MOUNT_ERR;
          end else begin
            slot_open[mslot]   <= 1'b1;
            slot_base[mslot]   <= nf[15:0];
            slot_count[mslot]  <= vblocks;
            slot_offset[mslot] <= voffset;
            nf                 <= alu_rsp.sum[17:0];
            res_action         <= bcdm_pkg::ACT_MOUNT_OK;
            res_base           <= nf[15:0];
          end
          state <= S_EMIT;
        end

        S_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_action;
            m_tdata  <= {6'd0, res_base, res_file, res_local, res_drive};
            state    <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Every accepted transaction moves the sequencer out of idle.
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state != S_IDLE))
    else $error("sequencer stayed idle after an accepted transaction");

  // A successful placement starts the clearing pass.
  a_mount_sweeps: assert property (@(posedge clk) disable iff (rst)
    ((state == S_PLACE) && nf_fits) |=> map_stat.busy)
    else $error("map clearing pass did not start after a mount");

  // The sequencer never writes the map while the clearing pass owns it.
  a_no_write_in_sweep: assert property (@(posedge clk) disable iff (rst)
    map_stat.busy |-> !map_req.wr_en)
    else $error("map write collided with the clearing pass");

  // An owned result always comes from an open slot.
  a_owner_open: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SCAN) && alu_rsp.lt && slot_open[idx]) |=> (state == S_OFFSET))
    else $error("owned block did not proceed to the offset step");

endmodule
